[rtl/pt1k_pkg.sv]
// ----------------------------------------------------------------------------
// pt1k_pkg
// shared types, constants and command codes of the pt1000 rtd converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pt1k_pkg;

  localparam int ADC_BITS     = 12;
  localparam int BISECT_STEPS = 22;
  localparam int DIV_STEPS    = 24;
  localparam int CNT_W        = $clog2((DIV_STEPS > BISECT_STEPS) ? DIV_STEPS : BISECT_STEPS);

  // conversion constants, q0.32
  localparam logic [29:0] GAIN_Q32 = 30'd916612260;
  localparam logic [31:0] K1_Q32   = 32'd999596515;

  // polynomial coefficients
  localparam logic signed [26:0] A_Q24  = 27'sd65570389;
  localparam logic        [21:0] B_Q32  = 22'd2480324;
  localparam logic signed [27:0] C_Q64  = 28'sd126671254;
  localparam logic signed [63:0] POLY_ONE = 64'sd1099511627776000;

  // bisection interval and offsets
  localparam logic [40:0]        SPAN_Q32  = 41'd1653562408960;
  localparam logic signed [26:0] T_OFFSET  = 27'sd327680;
  localparam logic [44:0]        TEMP_BIAS = 45'd214748364800;
  localparam logic signed [12:0] TEMP_50   = 13'sd50;

  // output scaling, divide by 256000 as shift by 11 and reciprocal of 125
  localparam logic [9:0]  SCALE_MUL  = 10'd1003;
  localparam logic [34:0] SCALE_RND  = 35'd128000;
  localparam logic [23:0] RECIP_125  = 24'd8589935;
  localparam int          RECIP_SHIFT = 30;

  // register indexes
  localparam logic [1:0] REG_UPDATE_TICKS = 2'd0;
  localparam logic [1:0] REG_PROBE_THRESH = 2'd1;
  localparam logic [1:0] REG_EMA_ALPHA    = 2'd2;

  localparam logic [9:0]  RST_UPDATE_TICKS = 10'd100;
  localparam logic [11:0] RST_PROBE_THRESH = 12'd2400;
  localparam logic [15:0] RST_EMA_ALPHA    = 16'd6554;

  localparam int OUT_W = 80;

  typedef struct packed {
    logic [9:0]  update_ticks;
    logic [11:0] probe_thresh;
    logic [15:0] ema_alpha;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CONV1,
    OP_CONV2,
    OP_DIV,
    OP_EMA1,
    OP_EMA2,
    OP_SCL1,
    OP_SCL2,
    OP_BINIT,
    OP_BMID,
    OP_BM1,
    OP_BM2,
    OP_BM3,
    OP_BCMP,
    OP_BFIN,
    OP_HOLD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ch;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] samp_zero;
  } stat_t;

endpackage

[rtl/pt1k_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pt1k_cfg_regs
// apb-style register file holding the converter settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pt1k_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output pt1k_pkg::cfg_t cfg
);

  pt1k_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_ticks <= pt1k_pkg::RST_UPDATE_TICKS;
      cfg_r.probe_thresh <= pt1k_pkg::RST_PROBE_THRESH;
      cfg_r.ema_alpha    <= pt1k_pkg::RST_EMA_ALPHA;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pt1k_pkg::REG_UPDATE_TICKS: cfg_r.update_ticks <= pwdata[9:0];
        pt1k_pkg::REG_PROBE_THRESH: cfg_r.probe_thresh <= pwdata[11:0];
        pt1k_pkg::REG_EMA_ALPHA:    cfg_r.ema_alpha    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pt1k_pkg::REG_UPDATE_TICKS: prdata = {22'd0, cfg_r.update_ticks};
      pt1k_pkg::REG_PROBE_THRESH: prdata = {20'd0, cfg_r.probe_thresh};
      pt1k_pkg::REG_EMA_ALPHA:    prdata = {16'd0, cfg_r.ema_alpha};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

[rtl/pt1k_datapath.sv]
// ----------------------------------------------------------------------------
// pt1k_datapath
// conversion, divider, filter, scaling and shared polynomial bisection unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pt1k_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pt1k_pkg::cmd_t                cmd,
  input  pt1k_pkg::cfg_t                cfg,
  input  logic [23:0]                   in_data,
  output pt1k_pkg::stat_t               stat,
  output logic [pt1k_pkg::OUT_W-1:0]    out_data
);

  // sample and filter state
  logic [11:0]        samp_r [2];
  logic [23:0]        filt_r [2];
  logic [15:0]        res_r  [2];
  logic signed [12:0] temp_r [2];
  logic signed [12:0] shown_r;
  logic               flag_r;

  // divider
  logic [31:0] d_r, den_r, rem_r;
  logic [23:0] q_r;
  // filter / scaling
  logic [39:0] p1_r;
  logic [23:0] y_r;
  // bisection
  logic [40:0]        lo_r, hi_r, mid_r;
  logic [51:0]        target_r;
  logic signed [26:0] t_r;
  logic signed [53:0] tt_r, at_r;
  logic signed [61:0] t2c_r;
  logic [55:0]        t2b_r;
  logic signed [57:0] cc_r;
  logic [pt1k_pkg::OUT_W-1:0] out_r;

  logic [11:0]                   s;
  logic [29+pt1k_pkg::ADC_BITS:0] sg;
  logic [43:0]        m3;
  logic [32:0]        sh;
  logic               ge;
  logic [40:0]        p2;
  logic [41:0]        esum;
  logic [34:0]        sx;
  logic [47:0]        qm;
  logic [41:0]        lh;
  logic [33:0]        t2;
  logic signed [61:0] cb;
  logic signed [57:0] ccb;
  logic signed [63:0] psum;
  logic [44:0]        v, w;
  logic signed [12:0] temp_nxt;
  logic               flag_nxt;

  assign stat.samp_zero = {samp_r[1] == 12'd0, samp_r[0] == 12'd0};
  assign out_data       = out_r;

  always_comb begin
    s    = samp_r[cmd.ch];
    sg   = s * pt1k_pkg::GAIN_Q32;
    m3   = 12'd3000 * d_r;
    sh   = {rem_r, q_r[23]};
    ge   = sh >= {1'b0, den_r};
    p2   = (17'd65536 - {1'b0, cfg.ema_alpha}) * filt_r[cmd.ch];
    esum = {2'b0, p1_r} + {1'b0, p2} + 42'd32768;
    sx   = filt_r[cmd.ch] * pt1k_pkg::SCALE_MUL + pt1k_pkg::SCALE_RND;
    qm   = y_r * pt1k_pkg::RECIP_125;
    lh   = {1'b0, lo_r} + {1'b0, hi_r};
    t2   = tt_r[49:16];
    // truncation toward zero on the two signed divides by powers of two
    cb   = t2c_r + (t2c_r[61] ? 62'sd4294967295 : 62'sd0);
    ccb  = cc_r + (cc_r[57] ? 58'sd16777215 : 58'sd0);
    psum = pt1k_pkg::POLY_ONE + 64'(at_r) - $signed({16'd0, t2b_r[55:8]})
           - 64'($signed(ccb[57:24]));
    v    = lh * 3'd5;
    w    = pt1k_pkg::TEMP_BIAS - v;
    if (v >= pt1k_pkg::TEMP_BIAS) begin
      temp_nxt = $signed(v[44:32]) - pt1k_pkg::TEMP_50;
    end else begin
      temp_nxt = -$signed(w[44:32]);
    end
    flag_nxt = res_r[1] < {cfg.probe_thresh, 4'd0};
  end

  // model state, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r[0] <= 24'd0;
      filt_r[1] <= 24'd0;
      temp_r[0] <= 13'sd0;
      temp_r[1] <= 13'sd0;
      shown_r   <= 13'sd0;
      flag_r    <= 1'b0;
    end else begin
      case (cmd.op)
        pt1k_pkg::OP_EMA2: filt_r[cmd.ch] <= esum[39:16];
        pt1k_pkg::OP_BFIN: temp_r[cmd.ch] <= temp_nxt;
        pt1k_pkg::OP_HOLD: begin
          flag_r  <= flag_nxt;
          shown_r <= flag_nxt ? temp_r[1] : temp_r[0];
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pt1k_pkg::OP_LOAD: begin
        samp_r[0] <= in_data[11:0];
        samp_r[1] <= in_data[23:12];
      end
      pt1k_pkg::OP_CONV1: d_r <= pt1k_pkg::K1_Q32 + 32'(sg >> pt1k_pkg::ADC_BITS);
      pt1k_pkg::OP_CONV2: begin
        rem_r <= m3[43:12];
        q_r   <= {m3[11:0], 12'd0};
        den_r <= 32'(33'h1_0000_0000 - {1'b0, d_r});
      end
      pt1k_pkg::OP_DIV: begin
        rem_r <= ge ? 32'(sh - {1'b0, den_r}) : sh[31:0];
        q_r   <= {q_r[22:0], ge};
      end
      pt1k_pkg::OP_EMA1: p1_r <= cfg.ema_alpha * q_r;
      pt1k_pkg::OP_SCL1: y_r <= sx[34:11];
      pt1k_pkg::OP_SCL2: res_r[cmd.ch] <= (qm[47:46] != 2'd0) ? 16'hFFFF : qm[45:30];
      pt1k_pkg::OP_BINIT: begin
        lo_r     <= 41'd0;
        hi_r     <= pt1k_pkg::SPAN_Q32;
        target_r <= {res_r[cmd.ch], 36'd0};
      end
      pt1k_pkg::OP_BMID: begin
        mid_r <= lh[41:1];
        t_r   <= $signed({2'b00, lh[41:17]}) - pt1k_pkg::T_OFFSET;
      end
      pt1k_pkg::OP_BM1: begin
        tt_r <= t_r * t_r;
        at_r <= pt1k_pkg::A_Q24 * t_r;
      end
      pt1k_pkg::OP_BM2: begin
        t2c_r <= $signed({1'b0, t2}) * t_r;
        t2b_r <= t2 * pt1k_pkg::B_Q32;
      end
      pt1k_pkg::OP_BM3: cc_r <= $signed(cb[61:32]) * pt1k_pkg::C_Q64;
      pt1k_pkg::OP_BCMP: begin
        if (psum > $signed({12'd0, target_r})) hi_r <= mid_r;
        else lo_r <= mid_r;
      end
      pt1k_pkg::OP_OUT: begin
        out_r <= {7'd0, flag_r, cmd.upd, shown_r, temp_r[1], temp_r[0], res_r[1], res_r[0]};
      end
      default: ;
    endcase
  end

endmodule

[rtl/pt1k_ctrl.sv]
// ----------------------------------------------------------------------------
// pt1k_ctrl
// sequencer for channel conversion, tick counting and bisection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pt1k_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  pt1k_pkg::cfg_t  cfg,
  input  pt1k_pkg::stat_t stat,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pt1k_pkg::cmd_t  cmd
);

  localparam int CNT_W_L = pt1k_pkg::CNT_W;

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1 << 0,
    S_CHAN  = 19'd1 << 1,
    S_CONV1 = 19'd1 << 2,
    S_CONV2 = 19'd1 << 3,
    S_DIV   = 19'd1 << 4,
    S_EMA1  = 19'd1 << 5,
    S_EMA2  = 19'd1 << 6,
    S_SCL1  = 19'd1 << 7,
    S_SCL2  = 19'd1 << 8,
    S_TICK  = 19'd1 << 9,
    S_BINIT = 19'd1 << 10,
    S_BMID  = 19'd1 << 11,
    S_BM1   = 19'd1 << 12,
    S_BM2   = 19'd1 << 13,
    S_BM3   = 19'd1 << 14,
    S_BCMP  = 19'd1 << 15,
    S_BFIN  = 19'd1 << 16,
    S_HOLD  = 19'd1 << 17,
    S_OUT   = 19'd1 << 18
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       ch_r, ch_nxt;
  logic                       upd_r, upd_nxt;
  logic [CNT_W_L-1:0]         cnt_r, cnt_nxt;
  logic [9:0]                 tick_r, tick_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       load;
  logic [10:0]                tick_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign tick_inc  = {1'b0, tick_r} + 11'd1;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    upd_nxt       = upd_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = pt1k_pkg::OP_NONE;
    cmd.ch        = ch_r;
    cmd.upd       = upd_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pt1k_pkg::OP_LOAD;
          ch_nxt    = 1'b1;
          state_nxt = S_CHAN;
        end
      end
      S_CHAN:  state_nxt = stat.samp_zero[ch_r] ? S_SCL1 : S_CONV1;
      S_CONV1: begin
        cmd.op    = pt1k_pkg::OP_CONV1;
        state_nxt = S_CONV2;
      end
      S_CONV2: begin
        cmd.op    = pt1k_pkg::OP_CONV2;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = pt1k_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W_L'(pt1k_pkg::DIV_STEPS - 1)) state_nxt = S_EMA1;
      end
      S_EMA1: begin
        cmd.op    = pt1k_pkg::OP_EMA1;
        state_nxt = S_EMA2;
      end
      S_EMA2: begin
        cmd.op    = pt1k_pkg::OP_EMA2;
        state_nxt = S_SCL1;
      end
      S_SCL1: begin
        cmd.op    = pt1k_pkg::OP_SCL1;
        state_nxt = S_SCL2;
      end
      S_SCL2: begin
        cmd.op = pt1k_pkg::OP_SCL2;
        if (ch_r) begin
          ch_nxt    = 1'b0;
          state_nxt = S_CHAN;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        if (tick_inc >= {1'b0, cfg.update_ticks}) begin
          tick_nxt  = 10'd0;
          upd_nxt   = 1'b1;
          ch_nxt    = 1'b1;
          state_nxt = S_BINIT;
        end else begin
          tick_nxt  = tick_inc[9:0];
          upd_nxt   = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_BINIT: begin
        cmd.op    = pt1k_pkg::OP_BINIT;
        cnt_nxt   = '0;
        state_nxt = S_BMID;
      end
      S_BMID: begin
        cmd.op    = pt1k_pkg::OP_BMID;
        state_nxt = S_BM1;
      end
      S_BM1: begin
        cmd.op    = pt1k_pkg::OP_BM1;
        state_nxt = S_BM2;
      end
      S_BM2: begin
        cmd.op    = pt1k_pkg::OP_BM2;
        state_nxt = S_BM3;
      end
      S_BM3: begin
        cmd.op    = pt1k_pkg::OP_BM3;
        state_nxt = S_BCMP;
      end
      S_BCMP: begin
        cmd.op  = pt1k_pkg::OP_BCMP;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == CNT_W_L'(pt1k_pkg::BISECT_STEPS - 1)) ? S_BFIN : S_BMID;
      end
      S_BFIN: begin
        cmd.op = pt1k_pkg::OP_BFIN;
        if (ch_r) begin
          ch_nxt    = 1'b0;
          state_nxt = S_BINIT;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.op    = pt1k_pkg::OP_HOLD;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          cmd.op        = pt1k_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      upd_r       <= 1'b0;
      cnt_r       <= '0;
      tick_r      <= 10'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      upd_r       <= upd_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/pt1000_rtd_temperature_converter_unit.sv]
// ----------------------------------------------------------------------------
// pt1000_rtd_temperature_converter_unit
// two-channel pt1000 converter: filtered resistance and cvd-inverse temperature
// ----------------------------------------------------------------------------
// per channel: conversion, a 24-step serial divider, filter and scaling; a zero sample
//   skips all but scaling; on an update tick 22 bisection steps per channel follow
// items: one at a time, a new item taken only once the last result is loaded into the
//   output register, which waits on out_tready; bisection runs on a shared polynomial unit
// reset: synchronous active low; filters, tick count and held temperatures clear,
//   registers return to 100 / 2400 / 6554
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pt1000_rtd_temperature_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // adc_table[11:0], adc_probe[23:12]
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  // res_table[15:0], res_probe[31:16], temp_table[44:32], temp_probe[57:45],
  // temp_shown[70:58], temps_updated[71], probe_present[72], zero fill
  output logic [79:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pt1k_pkg::cfg_t  cfg;
  pt1k_pkg::cmd_t  cmd;
  pt1k_pkg::stat_t stat;

  // register file; the user writes it only while idle, the block itself does not enforce this
  pt1k_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer: probe channel first, then table, then optional bisection
  pt1k_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stat      (stat),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  // arithmetic and held state, result register feeds out_tdata
  pt1k_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_tdata),
    .stat     (stat),
    .out_data (out_tdata)
  );

  // block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after accept");

  // shown temperature follows the probe flag
  a_shown_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[72] ? (out_tdata[70:58] == out_tdata[57:45])
                                  : (out_tdata[70:58] == out_tdata[44:32])))
    else $error("shown temperature does not match selected channel");

  // a new result only appears at the end of processing
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised while idle");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-channel pt1000 rtd converter: a built-in
// fixed-point predictor of the filter, scaling and cvd bisection checks every
// result item field by field under random idling, backpressure and register
// settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0]        res_table;
    logic [15:0]        res_probe;
    logic signed [12:0] temp_table;
    logic signed [12:0] temp_probe;
    logic signed [12:0] temp_shown;
    logic               updated;
    logic               present;
  } tick_result_t;

  typedef struct {
    logic [11:0]  adc_table;
    logic [11:0]  adc_probe;
    bit           typed;
    tick_result_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // adc_table[11:0], adc_probe[23:12]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // res_table, res_probe, temp_table, temp_probe, temp_shown, flags
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pt1000_rtd_temperature_converter_unit dut (.*);

  // predictor state and register copy
  longint unsigned filt[2];
  int unsigned     ticks_seen;
  logic signed [12:0] hold_tt, hold_tp, hold_ts;
  logic            hold_pres;
  int unsigned     upd_ticks, thresh, alpha;

  tick_result_t pending_q[$];
  int  err_cnt = 0;
  int  item_cnt = 0;
  int  upd_cnt = 0;
  bit  quiet = 0;
  bit  long_hold = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned sample_ohms(longint unsigned s);
    longint unsigned d;
    d = 64'd999596515 + ((s * 64'd916612260) >> 12);
    return ((64'd3000 * d) << 12) / ((64'd1 << 32) - d);
  endfunction

  function automatic void smooth(int ch, logic [11:0] s);
    longint unsigned r, f, a;
    if (s == 0) return;  // zero sample holds the filter
    r = sample_ohms(s);
    f = filt[ch];
    a = alpha;
    filt[ch] = ((a * r + (64'd65536 - a) * f + 64'd32768) >> 16) & 64'hFFFFFF;
  endfunction

  function automatic longint unsigned scale_out(longint unsigned f);
    longint unsigned r;
    r = (f * 64'd1003 + 64'd128000) / 64'd256000;
    return (r > 64'd65535) ? 64'd65535 : r;
  endfunction

  // cvd polynomial, t in q16 degrees, ohms in q40
  function automatic longint cvd_q40(longint t);
    longint t2, cube, sum;
    t2   = (t * t) >>> 16;
    cube = (t2 * t) / 64'sd4294967296;
    sum  = 64'sd1000 <<< 40;
    sum += 64'sd65570389 * t;
    sum -= (t2 * 64'sd2480324) >>> 8;
    sum -= (cube * 64'sd126671254) / 64'sd16777216;
    return sum;
  endfunction

  function automatic logic signed [12:0] ohms_to_tenths(longint unsigned res);
    longint unsigned lo, hi, mid, v;
    longint target, t;
    lo = 0;
    hi = 64'd385 << 32;
    target = $signed(res << 36);
    for (int i = 0; i < pt1k_pkg::BISECT_STEPS; i++) begin
      mid = (lo + hi) >> 1;
      t = $signed(mid >> 16) - (64'sd5 <<< 16);
      if (cvd_q40(t) > target) hi = mid;
      else lo = mid;
    end
    v = (lo + hi) * 64'd5;
    if (v >= (64'd50 << 32)) return 13'(int'(v >> 32) - 50);
    return 13'(-int'(((64'd50 << 32) - v) >> 32));
  endfunction

  function automatic tick_result_t convert_tick(logic [11:0] st, logic [11:0] sp);
    tick_result_t o;
    longint unsigned rt, rp;
    smooth(1, sp);
    smooth(0, st);
    rt = scale_out(filt[0]);
    rp = scale_out(filt[1]);
    o.updated = 0;
    if (ticks_seen + 1 >= upd_ticks) begin
      ticks_seen = 0;
      o.updated  = 1;
      hold_tp    = ohms_to_tenths(rp);
      hold_tt    = ohms_to_tenths(rt);
      hold_pres  = (rp < (longint'(thresh) << 4));
      hold_ts    = hold_pres ? hold_tp : hold_tt;
    end else begin
      ticks_seen = (ticks_seen + 1) & 10'h3FF;
    end
    o.res_table  = rt[15:0];
    o.res_probe  = rp[15:0];
    o.temp_table = hold_tt;
    o.temp_probe = hold_tp;
    o.temp_shown = hold_ts;
    o.present    = hold_pres;
    return o;
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_penable <= 0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    case (idx)
      pt1k_pkg::REG_UPDATE_TICKS: upd_ticks = val[9:0];
      pt1k_pkg::REG_PROBE_THRESH: thresh    = val[11:0];
      pt1k_pkg::REG_EMA_ALPHA:    alpha     = val[15:0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // stop offering, drain everything, then allow for a full update tick
  task automatic settle();
    in_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // valid stays high across back-to-back items, lowered only for a real gap
  task automatic send_item(logic [11:0] st, logic [11:0] sp, bit typed, tick_result_t want);
    int gap;
    tick_result_t got;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {sp, st};
    do @(posedge clk); while (!in_tready);
    got = convert_tick(st, sp);
    pending_q.push_back(typed ? want : got);
    item_cnt++;
    if (got.updated) upd_cnt++;
  endtask

  function automatic logic [11:0] pick_sample();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 12'd0;
    if (k == 1) return 12'hFFF;
    if (k == 2) return 12'd1;
    return 12'($urandom_range(1, 4095));
  endfunction

  // ----------------------------------------------------------------- receiver
  initial begin
    int stall;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    tick_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected");
        err_cnt++;
      end else begin
        w = pending_q.pop_front();
        if (out_tdata[15:0] !== w.res_table) begin
          $error("res_table exp %0d got %0d", w.res_table, out_tdata[15:0]); err_cnt++;
        end
        if (out_tdata[31:16] !== w.res_probe) begin
          $error("res_probe exp %0d got %0d", w.res_probe, out_tdata[31:16]); err_cnt++;
        end
        if (out_tdata[44:32] !== w.temp_table) begin
          $error("temp_table exp %0d got %0d", w.temp_table, $signed(out_tdata[44:32]));
          err_cnt++;
        end
        if (out_tdata[57:45] !== w.temp_probe) begin
          $error("temp_probe exp %0d got %0d", w.temp_probe, $signed(out_tdata[57:45]));
          err_cnt++;
        end
        if (out_tdata[70:58] !== w.temp_shown) begin
          $error("temp_shown exp %0d got %0d", w.temp_shown, $signed(out_tdata[70:58]));
          err_cnt++;
        end
        if (out_tdata[71] !== w.updated) begin
          $error("temps_updated exp %0d got %0d", w.updated, out_tdata[71]); err_cnt++;
        end
        if (out_tdata[72] !== w.present) begin
          $error("probe_present exp %0d got %0d", w.present, out_tdata[72]); err_cnt++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- limit
  initial begin
    #20000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------- main
  initial begin
    row_t rows[$];
    row_t r;
    tick_result_t nil;
    int lim;
    nil = '0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    filt[0] = 0;
    filt[1] = 0;
    ticks_seen = 0;
    hold_tt = 0;
    hold_tp = 0;
    hold_ts = 0;
    hold_pres = 0;
    upd_ticks = 100;
    thresh = 2400;
    alpha = 6554;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // after reset: empty filters, nothing recomputed yet
    r = '{12'd0, 12'd0, 1, '{16'd0, 16'd0, 13'sd0, 13'sd0, 13'sd0, 1'b0, 1'b0}};
    send_item(r.adc_table, r.adc_probe, r.typed, r.want);
    settle();
    reg_write(pt1k_pkg::REG_UPDATE_TICKS, 32'd1);
    // empty filters recompute to -4.9 degrees, probe reads present
    rows.push_back('{12'd0, 12'd0, 1,
                     '{16'd0, 16'd0, -13'sd49, -13'sd49, -13'sd49, 1'b1, 1'b1}});
    rows.push_back('{12'hFFF, 12'hFFF, 0, nil});
    rows.push_back('{12'd1, 12'd1, 0, nil});
    rows.push_back('{12'hFFF, 12'd0, 0, nil});
    rows.push_back('{12'd0, 12'hFFF, 0, nil});
    rows.push_back('{12'hAAA, 12'h555, 0, nil});
    rows.push_back('{12'h555, 12'hAAA, 0, nil});
    rows.push_back('{12'd2048, 12'd800, 0, nil});
    rows.push_back('{12'd800, 12'd2048, 0, nil});
    rows.push_back('{12'd1, 12'hFFF, 0, nil});
    foreach (rows[i]) send_item(rows[i].adc_table, rows[i].adc_probe, rows[i].typed,
                                rows[i].want);
    settle();
    // count of zero also recomputes every tick; fastest filter
    reg_write(pt1k_pkg::REG_UPDATE_TICKS, 32'd0);
    reg_write(pt1k_pkg::REG_EMA_ALPHA, 32'hFFFF);
    reg_write(pt1k_pkg::REG_PROBE_THRESH, 32'd4095);
    for (int i = 0; i < 6; i++) send_item(pick_sample(), pick_sample(), 0, nil);
    settle();
    // frozen filter: alpha of zero through the 16-bit mask
    reg_write(pt1k_pkg::REG_EMA_ALPHA, 32'hABCD0000);
    reg_write(pt1k_pkg::REG_PROBE_THRESH, 32'd0);
    for (int i = 0; i < 4; i++) send_item(pick_sample(), pick_sample(), 0, nil);
    settle();
    reg_write(REG_UNUSED, 32'hFFFFFFFF);  // unmapped register
    reg_write(pt1k_pkg::REG_EMA_ALPHA, 32'd1);

    // random phases, each under a new register setting
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: reg_write(pt1k_pkg::REG_UPDATE_TICKS, 32'd1000);
        3: reg_write(pt1k_pkg::REG_UPDATE_TICKS, 32'd1023);
        default: reg_write(pt1k_pkg::REG_UPDATE_TICKS, $urandom_range(0, 6));
      endcase
      // count lowered mid-way after the long-count phase
      if (ph == 1) reg_write(pt1k_pkg::REG_UPDATE_TICKS, 32'd3);
      reg_write(pt1k_pkg::REG_PROBE_THRESH, (ph % 4 == 0) ? 32'hFFF : $urandom());
      reg_write(pt1k_pkg::REG_EMA_ALPHA, (ph == 5) ? 32'hFFFF : $urandom());
      quiet = (ph % 3 == 2);
      lim = 60;
      for (int i = 0; i < lim; i++) begin
        if (ph == 4 && i == 10) long_hold = 1;  // receiver stalls, input backs up
        send_item(pick_sample(), pick_sample(), 0, nil);
      end
    end
    in_tvalid <= 0;
    quiet = 0;

    lim = 0;
    while (pending_q.size() != 0 && lim < 200000) begin
      @(posedge clk);
      lim++;
    end
    repeat (300) @(posedge clk);
    $display("covered %0d items, %0d with recomputed temperatures, %0d expectations left",
             item_cnt, upd_cnt, pending_q.size());
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
